// ===== sv/chat_format_code_stripper_top_macros.svh =====
// Assertion macros shared by the checker of the format-code stripper.
`ifndef CHAT_FORMAT_CODE_STRIPPER_TOP_MACROS_SVH
`define CHAT_FORMAT_CODE_STRIPPER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CFS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CFS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/cfs_pkg.sv =====
// Package with the types, constants and lookup functions of the format-code stripper.
package cfs_pkg;

    // Field widths of the channels.
    localparam int BYTE_W = 8;
    localparam int HINT_W = 3;
    localparam int LEN_W  = 13;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARSET_EBCDIC = 1'd1;
    localparam logic [CFG_DATA_W-1:0] OUTPUT_LIMIT_RESET = 13'd4096;
    localparam logic                  CHARSET_RESET      = 1'b1;

    // Default bound on kept bytes per message.
    localparam int MAX_MESSAGE_BYTES_DEF = 4096;

    // Queue between the parser and the result sequencer.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Control bytes of the message format.
    localparam logic [BYTE_W-1:0] CODE_BOLD      = 8'h02;
    localparam logic [BYTE_W-1:0] CODE_COLOR     = 8'h03;
    localparam logic [BYTE_W-1:0] CODE_HEX_COLOR = 8'h04;
    localparam logic [BYTE_W-1:0] CODE_RESET     = 8'h0F;
    localparam logic [BYTE_W-1:0] CODE_REVERSE   = 8'h16;
    localparam logic [BYTE_W-1:0] CODE_ITALIC    = 8'h1D;
    localparam logic [BYTE_W-1:0] CODE_STRIKE    = 8'h1E;
    localparam logic [BYTE_W-1:0] CODE_UNDERLINE = 8'h1F;
    localparam logic [BYTE_W-1:0] CODE_PRINTABLE = 8'h40;

    // Character codes that depend on the selected character set.
    localparam logic [BYTE_W-1:0] ASCII_DIGIT0  = 8'h30;
    localparam logic [BYTE_W-1:0] EBCDIC_DIGIT0 = 8'hF0;
    localparam logic [BYTE_W-1:0] ASCII_COMMA   = 8'h2C;
    localparam logic [BYTE_W-1:0] EBCDIC_COMMA  = 8'h6B;

    // Colour hint codes.
    localparam logic [HINT_W-1:0] HINT_NONE   = 3'd0;
    localparam logic [HINT_W-1:0] HINT_WHITE  = 3'd1;
    localparam logic [HINT_W-1:0] HINT_RED    = 3'd2;
    localparam logic [HINT_W-1:0] HINT_GREEN  = 3'd3;
    localparam logic [HINT_W-1:0] HINT_YELLOW = 3'd4;
    localparam logic [HINT_W-1:0] HINT_BLUE   = 3'd5;
    localparam logic [HINT_W-1:0] HINT_PURPLE = 3'd6;
    localparam logic [HINT_W-1:0] HINT_TEAL   = 3'd7;

    // One queue entry: the results caused by one input byte.
    typedef struct packed {
        logic [BYTE_W-1:0] byte0;
        logic [BYTE_W-1:0] byte1;
        logic [1:0]        n_bytes;
        logic              last;
        logic [HINT_W-1:0] hint;
        logic [LEN_W-1:0]  length;
    } t_entry;

    // Maps a colour number 0..15 to its hint; black gives none.
    function automatic logic [HINT_W-1:0] hint_of_color(input logic [3:0] color);
        logic [HINT_W-1:0] hint;
        unique case (color)
            4'd0:    hint = HINT_WHITE;
            4'd1:    hint = HINT_NONE;
            4'd2:    hint = HINT_BLUE;
            4'd3:    hint = HINT_GREEN;
            4'd4:    hint = HINT_RED;
            4'd5:    hint = HINT_RED;
            4'd6:    hint = HINT_PURPLE;
            4'd7:    hint = HINT_YELLOW;
            4'd8:    hint = HINT_YELLOW;
            4'd9:    hint = HINT_GREEN;
            4'd10:   hint = HINT_TEAL;
            4'd11:   hint = HINT_TEAL;
            4'd12:   hint = HINT_BLUE;
            4'd13:   hint = HINT_PURPLE;
            4'd14:   hint = HINT_WHITE;
            default: hint = HINT_WHITE;
        endcase
        return hint;
    endfunction

endpackage

// ===== sv/cfs_in_if.sv =====
// Input channel of the format-code stripper: message bytes with an end flag.
interface cfs_in_if;
    logic                      valid;
    logic                      ready;
    logic [cfs_pkg::BYTE_W-1:0] in_byte;
    logic                      end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

// ===== sv/cfs_out_if.sv =====
// Output channel of the format-code stripper: kept bytes and message summaries.
interface cfs_out_if;
    logic                      valid;
    logic                      ready;
    logic [cfs_pkg::BYTE_W-1:0] data_byte;
    logic                      byte_present;
    logic                      message_done;
    logic [cfs_pkg::HINT_W-1:0] color_hint;
    logic [cfs_pkg::LEN_W-1:0]  clean_length;

    modport source (output valid, output data_byte, output byte_present,
                    output message_done, output color_hint, output clean_length,
                    input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input message_done, input color_hint, input clean_length,
                    output ready);
endinterface

// ===== sv/chat_format_code_stripper_top.sv =====
// Top level of the chat format-code stripper: configuration registers and the three parts.
//
// Input channel i_in carries one message byte per transfer, with end_of_input on the
// final byte. Output channel o_out carries the results: each kept byte as its own
// transfer, and on the final result of a message message_done with the kept length
// and the colour hint. A byte that keeps nothing and is not final gives no result;
// a final byte that keeps nothing gives one result with byte_present low.
// One byte is taken per cycle while the queue has room. The parser updates its state in
// the cycle of the input transfer; if the queue was empty, the entry is at o_out in the
// following cycle. A byte that releases a held comma yields two results where both the
// comma and the byte are kept, from one entry of the four-entry queue. When the receiver
// stalls, the queue fills and i_in.ready drops once it holds four entries; no result is
// lost. Reset empties the queue, returns the parser to plain text and sets the limit to
// 4096 and the character set to EBCDIC. Configuration is written through i_cfg_wr_en,
// i_cfg_index and i_cfg_wdata, by the user only while idle; not enforced by the block.
module chat_format_code_stripper_top #(
    parameter int MAX_MESSAGE_BYTES = cfs_pkg::MAX_MESSAGE_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    cfs_in_if.sink                         i_in,
    cfs_out_if.source                      o_out,
    input  logic                           i_cfg_wr_en,
    input  logic [cfs_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cfs_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    logic [cfs_pkg::CFG_DATA_W-1:0] r_output_limit;
    logic                           r_charset_ebcdic;
    logic                           q_full, q_push, q_valid, q_pop;
    cfs_pkg::t_entry                q_wr_entry, q_rd_entry;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_output_limit   <= cfs_pkg::OUTPUT_LIMIT_RESET;
            r_charset_ebcdic <= cfs_pkg::CHARSET_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                cfs_pkg::CFG_OUTPUT_LIMIT:   r_output_limit   <= i_cfg_wdata;
                cfs_pkg::CFG_CHARSET_EBCDIC: r_charset_ebcdic <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Parser.
    cfs_front #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_in.valid),
        .i_byte           (i_in.in_byte),
        .i_last           (i_in.end_of_input),
        .o_ready          (i_in.ready),
        .i_output_limit   (r_output_limit),
        .i_charset_ebcdic (r_charset_ebcdic),
        .i_full           (q_full),
        .o_push           (q_push),
        .o_entry          (q_wr_entry)
    );

    // Entry queue.
    cfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_wr_entry),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_rd_entry),
        .i_pop   (q_pop)
    );

    // Result sequencer.
    cfs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .i_entry        (q_rd_entry),
        .o_pop          (q_pop),
        .o_valid        (o_out.valid),
        .i_ready        (o_out.ready),
        .o_data_byte    (o_out.data_byte),
        .o_byte_present (o_out.byte_present),
        .o_message_done (o_out.message_done),
        .o_color_hint   (o_out.color_hint),
        .o_clean_length (o_out.clean_length)
    );
endmodule

// ===== sv/cfs_front.sv =====
// Front part: parses each byte, tracks colour codes and the kept count, builds queue entries.
module cfs_front #(
    parameter int MAX_MESSAGE_BYTES = cfs_pkg::MAX_MESSAGE_BYTES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [cfs_pkg::BYTE_W-1:0]    i_byte,
    input  logic                          i_last,
    output logic                          o_ready,
    input  logic [cfs_pkg::CFG_DATA_W-1:0] i_output_limit,
    input  logic                          i_charset_ebcdic,
    input  logic                          i_full,
    output logic                          o_push,
    output cfs_pkg::t_entry               o_entry
);
    localparam int CW   = $clog2(MAX_MESSAGE_BYTES + 1);
    localparam int CMPW = (CW > cfs_pkg::LEN_W) ? CW : cfs_pkg::LEN_W;
    localparam logic [CMPW-1:0] MAX_C = CMPW'(MAX_MESSAGE_BYTES);

    // Parser modes.
    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_FG     = 3'd1;
    localparam logic [2:0] MODE_COMMA  = 3'd2;
    localparam logic [2:0] MODE_BG     = 3'd3;
    localparam logic [2:0] MODE_HEX1   = 3'd4;
    localparam logic [2:0] MODE_HEX2   = 3'd5;

    logic [2:0]                 r_mode, n_mode;
    logic [2:0]                 r_dc, n_dc;
    logic [6:0]                 r_fg, n_fg;
    logic                       r_seen, n_seen;
    logic [CW-1:0]              r_kept, n_kept;
    logic [cfs_pkg::HINT_W-1:0] r_dom, n_dom;

    logic [cfs_pkg::BYTE_W-1:0] digit0, comma_code, digit_off;
    logic                       c_dig, c_comma, c_hex;
    logic [3:0]                 c_val;
    logic [9:0]                 fg_times10, fg_sum;
    logic [2:0]                 dc_inc;
    logic [CMPW-1:0]            lim, kept_ext, kept_sum;
    logic                       ok0, ok1, ok_b;
    logic                       take, do_plain, do_comma, keep_c, keep_b;
    logic                       accept;

    // Character classes under the selected character set.
    always_comb begin
        digit0     = i_charset_ebcdic ? cfs_pkg::EBCDIC_DIGIT0 : cfs_pkg::ASCII_DIGIT0;
        comma_code = i_charset_ebcdic ? cfs_pkg::EBCDIC_COMMA : cfs_pkg::ASCII_COMMA;
        digit_off  = i_byte - digit0;
        c_dig      = (i_byte >= digit0) && (digit_off <= 8'd9);
        c_val      = digit_off[3:0];
        c_comma    = (i_byte == comma_code);
        if (i_charset_ebcdic) begin
            c_hex = c_dig || ((i_byte >= 8'hC1) && (i_byte <= 8'hC6))
                          || ((i_byte >= 8'h81) && (i_byte <= 8'h86));
        end else begin
            c_hex = c_dig || ((i_byte >= 8'h41) && (i_byte <= 8'h46))
                          || ((i_byte >= 8'h61) && (i_byte <= 8'h66));
        end
    end

    // Effective limit and the kept-count checks for one or two kept bytes.
    always_comb begin
        lim      = (CMPW'(i_output_limit) > MAX_C) ? MAX_C : CMPW'(i_output_limit);
        kept_ext = CMPW'(r_kept);
        ok0      = kept_ext < lim;
        ok1      = (kept_ext + CMPW'(1)) < lim;
    end

    // Foreground number accumulation and digit count step.
    always_comb begin
        fg_times10 = {r_fg, 3'b000} + {2'b00, r_fg, 1'b0};
        fg_sum     = fg_times10 + {6'b000000, c_val};
        dc_inc     = r_dc + 3'd1;
    end

    // Mode update, held comma release and plain-byte handling.
    always_comb begin
        n_mode   = r_mode;
        n_dc     = r_dc;
        n_fg     = r_fg;
        n_seen   = r_seen;
        n_dom    = r_dom;
        take     = 1'b0;
        do_plain = 1'b0;
        do_comma = 1'b0;
        keep_b   = 1'b0;

        unique case (r_mode)
            MODE_FG: begin
                if ((r_dc < 3'd2) && c_dig) begin
                    n_fg   = fg_sum[6:0];
                    n_seen = 1'b1;
                    n_dc   = dc_inc;
                end else begin
                    take   = 1'b1;
                    n_mode = MODE_NORMAL;
                    if (c_comma && !i_last) begin
                        n_mode = MODE_COMMA;
                    end else begin
                        do_plain = 1'b1;
                    end
                end
            end
            MODE_COMMA: begin
                n_mode = MODE_NORMAL;
                if (c_dig) begin
                    n_mode = MODE_BG;
                    n_dc   = 3'd1;
                end else begin
                    do_comma = 1'b1;
                    do_plain = 1'b1;
                end
            end
            MODE_BG: begin
                if ((r_dc < 3'd2) && c_dig) begin
                    n_dc = dc_inc;
                    if (dc_inc >= 3'd2) begin
                        n_mode = MODE_NORMAL;
                    end
                end else begin
                    n_mode   = MODE_NORMAL;
                    do_plain = 1'b1;
                end
            end
            MODE_HEX1: begin
                if ((r_dc < 3'd6) && c_hex) begin
                    n_dc = dc_inc;
                end else if (c_comma) begin
                    n_mode = MODE_HEX2;
                    n_dc   = 3'd0;
                end else begin
                    n_mode   = MODE_NORMAL;
                    do_plain = 1'b1;
                end
            end
            MODE_HEX2: begin
                if ((r_dc < 3'd6) && c_hex) begin
                    n_dc = dc_inc;
                    if (dc_inc >= 3'd6) begin
                        n_mode = MODE_NORMAL;
                    end
                end else begin
                    n_mode   = MODE_NORMAL;
                    do_plain = 1'b1;
                end
            end
            default: begin
                n_mode   = MODE_NORMAL;
                do_plain = 1'b1;
            end
        endcase

        // The foreground number ends here: take its hint if none is held yet.
        if (take && r_seen && (r_dom == cfs_pkg::HINT_NONE) && (r_fg < 7'd16)) begin
            n_dom = cfs_pkg::hint_of_color(r_fg[3:0]);
        end

        // A released comma is kept only where it is printable and room is left.
        keep_c = do_comma && ok0 && (comma_code >= cfs_pkg::CODE_PRINTABLE);
        ok_b   = keep_c ? ok1 : ok0;

        if (do_plain && ok_b) begin
            unique case (i_byte)
                cfs_pkg::CODE_BOLD, cfs_pkg::CODE_RESET, cfs_pkg::CODE_REVERSE,
                cfs_pkg::CODE_ITALIC, cfs_pkg::CODE_STRIKE,
                cfs_pkg::CODE_UNDERLINE: begin
                    keep_b = 1'b0;
                end
                cfs_pkg::CODE_COLOR: begin
                    n_mode = MODE_FG;
                    n_dc   = 3'd0;
                    n_fg   = 7'd0;
                    n_seen = 1'b0;
                end
                cfs_pkg::CODE_HEX_COLOR: begin
                    n_mode = MODE_HEX1;
                    n_dc   = 3'd0;
                end
                default: begin
                    keep_b = (i_byte >= cfs_pkg::CODE_PRINTABLE);
                end
            endcase
        end

        // A message that ends inside the foreground digits still gives its hint.
        if (i_last && (n_mode == MODE_FG) && n_seen && (n_dom == cfs_pkg::HINT_NONE)
                && (n_fg < 7'd16)) begin
            n_dom = cfs_pkg::hint_of_color(n_fg[3:0]);
        end

        kept_sum = kept_ext + CMPW'(keep_c) + CMPW'(keep_b);
        n_kept   = kept_sum[CW-1:0];
    end

    // Queue entry for this byte.
    always_comb begin
        o_entry.byte0   = keep_c ? comma_code : i_byte;
        o_entry.byte1   = i_byte;
        o_entry.n_bytes = {1'b0, keep_c} + {1'b0, keep_b};
        o_entry.last    = i_last;
        o_entry.hint    = n_dom;
        o_entry.length  = kept_sum[cfs_pkg::LEN_W-1:0];
    end

    assign o_ready = !i_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && (keep_c || keep_b || i_last);

    // Parser state; the end of a message returns it to its reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_NORMAL;
            r_dc   <= 3'd0;
            r_fg   <= 7'd0;
            r_seen <= 1'b0;
            r_kept <= '0;
            r_dom  <= cfs_pkg::HINT_NONE;
        end else if (accept) begin
            if (i_last) begin
                r_mode <= MODE_NORMAL;
                r_dc   <= 3'd0;
                r_fg   <= 7'd0;
                r_seen <= 1'b0;
                r_kept <= '0;
                r_dom  <= cfs_pkg::HINT_NONE;
            end else begin
                r_mode <= n_mode;
                r_dc   <= n_dc;
                r_fg   <= n_fg;
                r_seen <= n_seen;
                r_kept <= n_kept;
                r_dom  <= n_dom;
            end
        end
    end
endmodule

// ===== sv/cfs_queue.sv =====
// Short entry queue that decouples the parser from the result sequencer.
module cfs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cfs_pkg::t_entry i_entry,
    output logic            o_full,
    output logic            o_valid,
    output cfs_pkg::t_entry o_entry,
    input  logic            i_pop
);
    cfs_pkg::t_entry                 r_slot [cfs_pkg::QUEUE_DEPTH];
    logic [cfs_pkg::QPTR_W-1:0]      r_wr_ptr, r_rd_ptr;
    logic [cfs_pkg::QCNT_W-1:0]      r_count, n_count;

    assign o_full  = (r_count == cfs_pkg::QCNT_W'(cfs_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_slot[r_rd_ptr];

    // Occupancy after this cycle's push and pop.
    always_comb begin
        n_count = r_count + cfs_pkg::QCNT_W'(i_push) - cfs_pkg::QCNT_W'(i_pop);
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and occupancy; the pointers wrap with the power-of-two depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + cfs_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + cfs_pkg::QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end
endmodule

// ===== sv/cfs_back.sv =====
// Back part: turns each queue entry into one or two result transfers.
module cfs_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  cfs_pkg::t_entry            i_entry,
    output logic                       o_pop,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [cfs_pkg::BYTE_W-1:0] o_data_byte,
    output logic                       o_byte_present,
    output logic                       o_message_done,
    output logic [cfs_pkg::HINT_W-1:0] o_color_hint,
    output logic [cfs_pkg::LEN_W-1:0]  o_clean_length
);
    logic r_sub;
    logic last_res, present, done, xfer;

    // Which result of the entry is on show, and what it carries.
    always_comb begin
        last_res = (i_entry.n_bytes != 2'd2) || r_sub;
        present  = r_sub || (i_entry.n_bytes != 2'd0);
        done     = i_entry.last && last_res;
        xfer     = i_valid && i_ready;
    end

    assign o_valid        = i_valid;
    assign o_byte_present = present;
    assign o_data_byte    = present ? (r_sub ? i_entry.byte1 : i_entry.byte0) : '0;
    assign o_message_done = done;
    assign o_color_hint   = done ? i_entry.hint : cfs_pkg::HINT_NONE;
    assign o_clean_length = done ? i_entry.length : '0;
    assign o_pop          = xfer && last_res;

    // Result index within the current entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= 1'b0;
        end else if (xfer) begin
            r_sub <= !last_res;
        end
    end
endmodule

// ===== sv/cfs_checker.sv =====
// Port-level checker of the format-code stripper and its bind to the top level.
`include "chat_format_code_stripper_top_macros.svh"

module cfs_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       i_ready,
    input logic [cfs_pkg::BYTE_W-1:0] i_data_byte,
    input logic                       i_byte_present,
    input logic                       i_message_done,
    input logic [cfs_pkg::HINT_W-1:0] i_color_hint,
    input logic [cfs_pkg::LEN_W-1:0]  i_clean_length
);
    // A stalled result stays offered, with its byte, byte flag and done flag unchanged.
    `CFS_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_data_byte) && $stable(i_byte_present) && $stable(i_message_done), "stalled result changed")

    // A result without a byte only ever closes a message and carries a zero byte.
    `CFS_ASSERT_SAME(a_empty_is_final, i_clk, i_rst_n, i_valid && !i_byte_present, i_message_done && (i_data_byte == '0), "empty result that does not close a message")

    // Summary fields stay zero on results that do not close a message.
    `CFS_ASSERT_SAME(a_summary_only_at_end, i_clk, i_rst_n, i_valid && !i_message_done, (i_color_hint == cfs_pkg::HINT_NONE) && (i_clean_length == '0), "summary fields set before message end")

    // A message that closes on a kept byte has kept at least one byte.
    `CFS_ASSERT_SAME(a_length_counts_byte, i_clk, i_rst_n, i_valid && i_message_done && i_byte_present, i_clean_length != '0, "kept byte not counted in length")
endmodule

bind chat_format_code_stripper_top cfs_checker u_cfs_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_out.valid),
    .i_ready        (o_out.ready),
    .i_data_byte    (o_out.data_byte),
    .i_byte_present (o_out.byte_present),
    .i_message_done (o_out.message_done),
    .i_color_hint   (o_out.color_hint),
    .i_clean_length (o_out.clean_length)
);
